// ===== sv/occupancy_grid_disk_rasterizer_defines.svh =====
// Assertion macros shared by the occupancy grid disk rasterizer RTL.
`ifndef OCCUPANCY_GRID_DISK_RASTERIZER_DEFINES_SVH
`define OCCUPANCY_GRID_DISK_RASTERIZER_DEFINES_SVH
`ifndef SYNTH
`define OGDR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define OGDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define OGDR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define OGDR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ogdr_pkg.sv =====
// Package with operation codes, register indexes and defaults of the rasterizer.
package ogdr_pkg;
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [1:0] CFG_SIDE = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_ENABLE = 2'd2;

  localparam int GRID_SIDE_MAX_DEF = 512;
  localparam int WORD_BITS_DEF = 64;

  localparam logic [9:0] SIDE_RESET = 10'd400;
  localparam logic [15:0] RADIUS_RESET = 16'd3072;
endpackage

// ===== sv/ogdr_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ogdr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/occupancy_grid_disk_rasterizer.sv =====
// Top level of the occupancy grid disk rasterizer: sequencer, square root unit and map RAM.
//
// Items arrive on item_valid/item_stall; a transfer takes place when item_valid is high
// and item_stall is low. Each item gives one result on result_valid/result_stall,
// held steady until the receiver drops result_stall. item_stall stays high from a
// transfer until its result has been taken, so one item is in flight at a time.
// Registers are written on cfg_valid/cfg_ready, which is always ready.
// A read checks the address, reads the map RAM and registers the word; an address
// past the used map gives status high and zero data. A clear sweeps the map RAM,
// one word per cycle. With marking enabled, an add computes, for each row of the
// disk, a square root bit by bit over a shared 32-bit add and compare unit, then
// reads and writes each map word the row touches through the single RAM port pair.
// Rows outside the map are skipped. After reset the block sweeps the map to zero
// with item_stall high; registers take their reset values at once and may be written
// meanwhile. A held result stays until result_stall drops; nothing is accepted till then.
module occupancy_grid_disk_rasterizer
  import ogdr_pkg::*;
#(
  parameter int GRID_SIDE_MAX = GRID_SIDE_MAX_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           func,
  input  logic signed [20:0]   center_x,
  input  logic signed [20:0]   center_y,
  input  logic [11:0]          word_address,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [WORD_BITS-1:0] read_data,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  `include "occupancy_grid_disk_rasterizer_defines.svh"

  localparam int SW = $clog2(GRID_SIDE_MAX + 1);
  localparam int IDX_W = $clog2(GRID_SIDE_MAX * GRID_SIDE_MAX);
  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int ADDR_W = IDX_W - BIT_W;
  localparam int DEPTH = (GRID_SIDE_MAX * GRID_SIDE_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int CRD_W = (SW + 9 > 23) ? SW + 9 : 23;
  localparam int CEL_W = CRD_W - 8;

  typedef enum logic [12:0] {
    S_SWEEP  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ADD    = 13'b0000000000100,
    S_ROW    = 13'b0000000001000,
    S_SQRT0  = 13'b0000000010000,
    S_SQRT   = 13'b0000000100000,
    S_SPAN   = 13'b0000001000000,
    S_WORDS  = 13'b0000010000000,
    S_RD     = 13'b0000100000000,
    S_WR     = 13'b0001000000000,
    S_RDCHK  = 13'b0010000000000,
    S_RDWAIT = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [9:0]  map_side_cells;
  logic [15:0] radius_cells;
  logic        enable_marking;

  logic               sweep_reply;
  logic [ADDR_W-1:0]  clr_addr;
  logic signed [20:0] cx;
  logic signed [20:0] cy;
  logic [11:0]        addr;
  logic [31:0]        rsq;
  logic signed [17:0] dy;
  logic [31:0]        dysq;
  logic [IDX_W-1:0]   row_base;
  logic [31:0]        v;
  logic [31:0]        res;
  logic [31:0]        bitm;
  logic [3:0]         iter;
  logic [SW-1:0]      ilo;
  logic [SW-1:0]      ihi;
  logic               span_ok;
  logic [ADDR_W-1:0]  a_word;
  logic [BIT_W-1:0]   a_lo;
  logic [ADDR_W-1:0]  b_word;
  logic [BIT_W-1:0]   b_hi;
  logic [ADDR_W-1:0]  cur_word;

  logic [SW-1:0]             side;
  logic signed [CRD_W-1:0]   off;
  logic signed [CRD_W-1:0]   ysum;
  logic signed [CRD_W-1:0]   xsum;
  logic signed [CEL_W-1:0]   j_c;
  logic signed [CEL_W-1:0]   i0;
  logic signed [CEL_W-1:0]   ilast;
  logic signed [CEL_W-1:0]   side_c;
  logic [SW-1:0]             j_u;
  logic                      row_in;
  logic signed [17:0]        r_s;
  logic signed [35:0]        dy_sq_full;
  logic [31:0]               r_sq;
  logic [32:0]               trial;
  logic [IDX_W-1:0]          a_idx;
  logic [IDX_W-1:0]          b_idx;
  logic [IDX_W+1:0]          side_sq;
  logic [IDX_W+1:0]          used;
  logic                      rd_bad;
  logic [BIT_W-1:0]          lo_b;
  logic [BIT_W-1:0]          hi_b;
  logic [WORD_BITS-1:0]      ones;
  logic [WORD_BITS-1:0]      mask;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  always_comb begin
    if (map_side_cells == 10'd0) begin
      side = SW'(1);
    end else if (32'(map_side_cells) > GRID_SIDE_MAX) begin
      side = SW'(GRID_SIDE_MAX);
    end else begin
      side = SW'(map_side_cells);
    end
  end

  assign off = signed'(CRD_W'({side, 7'b0}) + CRD_W'(128));
  assign ysum = CRD_W'(cy) + CRD_W'(dy) + off;
  assign j_c = ysum[CRD_W-1:8];
  assign j_u = j_c[SW-1:0];
  assign side_c = signed'(CEL_W'(side));
  assign row_in = !j_c[CEL_W-1] && (j_c < side_c);
  assign xsum = CRD_W'(cx) - CRD_W'(signed'({1'b0, res[15:0]})) + off;
  assign i0 = xsum[CRD_W-1:8];
  assign ilast = i0 + signed'(CEL_W'(res[15:7]));
  assign r_s = signed'({2'b0, radius_cells});
  assign dy_sq_full = dy * dy;
  assign r_sq = radius_cells * radius_cells;
  assign trial = {1'b0, res} + {1'b0, bitm};
  assign a_idx = row_base + IDX_W'(ilo);
  assign b_idx = row_base + IDX_W'(ihi);
  assign side_sq = (IDX_W + 2)'(side) * (IDX_W + 2)'(side);
  assign used = (side_sq + (IDX_W + 2)'(WORD_BITS - 1)) >> BIT_W;
  assign rd_bad = (32'(addr) >= 32'(used)) || (32'(addr) >= DEPTH);

  assign ones = '1;
  assign lo_b = (cur_word == a_word) ? a_lo : '0;
  assign hi_b = (cur_word == b_word) ? b_hi : '1;
  assign mask = (ones << lo_b) & (ones >> (BIT_W'(WORD_BITS - 1) - hi_b));

  assign ram_we = (state == S_SWEEP) || (state == S_WR);
  assign ram_waddr = (state == S_SWEEP) ? clr_addr : cur_word;
  assign ram_wdata = (state == S_SWEEP) ? '0 : (ram_rdata | mask);
  assign ram_raddr = (state == S_RDCHK) ? ADDR_W'(addr) : cur_word;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  ogdr_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_side_cells <= SIDE_RESET;
      radius_cells <= RADIUS_RESET;
      enable_marking <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIDE: map_side_cells <= cfg_data[9:0];
        CFG_RADIUS: radius_cells <= cfg_data;
        CFG_ENABLE: enable_marking <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      clr_addr <= '0;
      sweep_reply <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            if (sweep_reply) begin
              read_data <= '0;
              status <= 1'b0;
              result_valid <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            cx <= center_x;
            cy <= center_y;
            addr <= word_address;
            case (func)
              FUNC_CLEAR: begin
                clr_addr <= '0;
                sweep_reply <= 1'b1;
                state <= S_SWEEP;
              end
              FUNC_ADD: begin
                if (enable_marking) begin
                  state <= S_ADD;
                end else begin
                  read_data <= '0;
                  status <= 1'b0;
                  result_valid <= 1'b1;
                  state <= S_DONE;
                end
              end
              FUNC_READ: state <= S_RDCHK;
              default: begin
                read_data <= '0;
                status <= 1'b0;
                result_valid <= 1'b1;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_ADD: begin
          rsq <= r_sq;
          dy <= -r_s;
          state <= S_ROW;
        end
        S_ROW: begin
          if (dy >= r_s) begin
            read_data <= '0;
            status <= 1'b0;
            result_valid <= 1'b1;
            state <= S_DONE;
          end else if (!row_in) begin
            dy <= dy + 18'sd256;
          end else begin
            dysq <= dy_sq_full[31:0];
            row_base <= IDX_W'(IDX_W'(j_u) * IDX_W'(side));
            state <= S_SQRT0;
          end
        end
        S_SQRT0: begin
          v <= rsq - dysq;
          res <= '0;
          bitm <= 32'h4000_0000;
          iter <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, v} >= trial) begin
            v <= v - trial[31:0];
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          iter <= iter + 4'd1;
          if (iter == 4'd15) begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          span_ok <= !ilast[CEL_W-1] && (i0 < side_c);
          ilo <= i0[CEL_W-1] ? '0 : i0[SW-1:0];
          ihi <= (ilast >= side_c) ? side - SW'(1) : ilast[SW-1:0];
          state <= S_WORDS;
        end
        S_WORDS: begin
          if (!span_ok) begin
            dy <= dy + 18'sd256;
            state <= S_ROW;
          end else begin
            a_word <= a_idx[IDX_W-1:BIT_W];
            a_lo <= a_idx[BIT_W-1:0];
            b_word <= b_idx[IDX_W-1:BIT_W];
            b_hi <= b_idx[BIT_W-1:0];
            cur_word <= a_idx[IDX_W-1:BIT_W];
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (cur_word == b_word) begin
            dy <= dy + 18'sd256;
            state <= S_ROW;
          end else begin
            cur_word <= cur_word + ADDR_W'(1);
            state <= S_RD;
          end
        end
        S_RDCHK: begin
          if (rd_bad) begin
            read_data <= '0;
            status <= 1'b1;
            result_valid <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          read_data <= ram_rdata;
          status <= 1'b0;
          result_valid <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            sweep_reply <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OGDR_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && !item_stall, item_stall)
  `OGDR_ASSERT_IMPLY(a_result_in_done, clk, rst, result_valid, state == S_DONE)
  `OGDR_ASSERT_IMPLY(a_status_zero_data, clk, rst, result_valid && status, read_data == '0)
  `OGDR_ASSERT_NEXT(a_read_then_write, clk, rst, state == S_RD, state == S_WR)
endmodule
